// ----- hdl/vssc_pkg.sv -----
package vssc_pkg;

  // Field widths of the stream payloads
  localparam int SPEED_W = 25;
  localparam int DEV_W   = 16;
  localparam int TAG_W   = 32;
  localparam int ANGLE_W = 15;
  localparam int Q_W     = 24;
  localparam int BRAKE_W = 8;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 64;

  // PID datapath widths
  localparam int ERR_W   = 26;
  localparam int DIFF_W  = 27;
  localparam int INTEG_W = 48;
  localparam int MAGI_W  = 47;
  localparam int IHALF_W = 24;
  localparam int TERM_W  = 62;
  localparam int SUM_W   = 63;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic [70:0] TERM_SAT = 71'd1 << 60;

  // Steering constants in 0.01 units
  localparam logic signed [DEV_W-1:0] DEV_FAR    = 16'sd350;
  localparam logic signed [DEV_W-1:0] DEV_NEAR   = 16'sd10;
  localparam logic signed [15:0]      STEER_STEP = 16'sd2000;
  localparam logic signed [15:0]      STEER_MAX  = 16'sd3000;
  localparam logic signed [15:0]      REAR_MAX   = 16'sd16383;

  typedef enum logic [2:0] {
    REG_DESIRED_SPEED   = 3'd0,
    REG_GAIN_P          = 3'd1,
    REG_GAIN_I          = 3'd2,
    REG_GAIN_D          = 3'd3,
    REG_TORQUE_OFFSET   = 3'd4,
    REG_TORQUE_LIMIT    = 3'd5,
    REG_BRAKE_LEVEL     = 3'd6,
    REG_DESTINATION_TAG = 3'd7
  } cfg_reg_t;

  // Result fields decided at the input stage, carried down the pipeline
  typedef struct packed {
    logic                      use_pid;
    logic [Q_W-1:0]            torque;
    logic [BRAKE_W-1:0]        brake;
    logic signed [ANGLE_W-1:0] front;
    logic signed [ANGLE_W-1:0] rear;
    logic                      arrived;
  } side_t;

endpackage

// ----- hdl/vehicle_speed_steer_control_step.sv -----
// Speed and steering controller, one command per control tick. A tick is taken
// in every cycle unless m_axis_tready holds the pipeline. The input stage
// updates the integral, the last error and the steering state, then three
// stages form the gain products (the integral one as 24x24 and 24x23 halves),
// the saturated terms and their sum; the last stage clamps the torque into the
// output register. The input-stage update is the only loop between ticks,
// so back-to-back ticks see each other's state. Torque is Q8.16 by default
// (FRACTION_BITS), angles and deviation are in 0.01 units. Once the
// destination tag is seen the block brakes and echoes the measured angles.
module vehicle_speed_steer_control_step #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // measured_speed, front_deviation, front_tag, front_angle, rear_angle
  input  logic [vssc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // start_action, front_angle_valid
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // torque_command, brake_command, front_steer_target, rear_steer_target
  output logic [vssc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // arrived
  output logic [0:0]                      m_axis_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  vssc_pkg::cfg_reg_t              cfg_index,
  input  logic [31:0]                     cfg_data
);
  import vssc_pkg::*;

  localparam longint unsigned ONE_Q = 64'd1 << FRACTION_BITS;
  localparam logic [Q_W-1:0] TORQUE_ONE =
    (ONE_Q > 64'hFF_FFFF) ? 24'hFF_FFFF : ONE_Q[Q_W-1:0];
  localparam logic [Q_W-1:0] TORQUE_FLOOR =
    24'(((64'd1 << FRACTION_BITS) + 64'd500) / 64'd1000);

  // Configuration registers
  logic [Q_W-1:0]     desired_speed, gain_p, gain_i, gain_d;
  logic [Q_W-1:0]     torque_offset, torque_limit;
  logic [BRAKE_W-1:0] brake_level;
  logic [TAG_W-1:0]   destination_tag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      desired_speed   <= '0;
      gain_p          <= '0;
      gain_i          <= '0;
      gain_d          <= '0;
      torque_offset   <= '0;
      torque_limit    <= '0;
      brake_level     <= 8'd10;
      destination_tag <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DESIRED_SPEED:   desired_speed   <= cfg_data[Q_W-1:0];
        REG_GAIN_P:          gain_p          <= cfg_data[Q_W-1:0];
        REG_GAIN_I:          gain_i          <= cfg_data[Q_W-1:0];
        REG_GAIN_D:          gain_d          <= cfg_data[Q_W-1:0];
        REG_TORQUE_OFFSET:   torque_offset   <= cfg_data[Q_W-1:0];
        REG_TORQUE_LIMIT:    torque_limit    <= cfg_data[Q_W-1:0];
        REG_BRAKE_LEVEL:     brake_level     <= cfg_data[BRAKE_W-1:0];
        REG_DESTINATION_TAG: destination_tag <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input fields
  logic signed [SPEED_W-1:0] in_speed;
  logic signed [DEV_W-1:0]   in_dev;
  logic [TAG_W-1:0]          in_tag;
  logic signed [ANGLE_W-1:0] in_fang, in_rang;
  logic                      in_start, in_fvalid;

  assign in_speed  = s_axis_tdata[24:0];
  assign in_dev    = s_axis_tdata[40:25];
  assign in_tag    = s_axis_tdata[72:41];
  assign in_fang   = s_axis_tdata[87:73];
  assign in_rang   = s_axis_tdata[102:88];
  assign in_start  = s_axis_tuser[0];
  assign in_fvalid = s_axis_tuser[1];

  // Pipeline handshake: a stage loads when it is empty or its successor moves
  logic v1, v2, v3, v4, v5;
  logic r2, r3, r4, r5;
  logic accept;

  assign r5            = !v5 || m_axis_tready;
  assign r4            = !v4 || r5;
  assign r3            = !v3 || r4;
  assign r2            = !v2 || r3;
  assign s_axis_tready = !v1 || r2;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (s_axis_tready) v1 <= s_axis_tvalid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  // Controller state
  logic signed [INTEG_W-1:0] error_integral;
  logic signed [ERR_W-1:0]   previous_error;
  logic signed [15:0]        front_hold;
  logic                      steering_awake, angle_seen, arrived_latch;

  logic                      tag_hit, run_pid, arrived_next, angle_seen_next, wake;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] error_integral_next;
  logic signed [15:0]        target_raw, target, rear_neg, front_hold_next;
  side_t                     side_in;

  always_comb begin
    tag_hit         = (in_tag == destination_tag);
    run_pid         = !tag_hit && in_start;
    arrived_next    = arrived_latch || tag_hit;
    angle_seen_next = angle_seen || in_fvalid;
    wake            = !steering_awake && angle_seen_next && in_start;

    err  = ERR_W'($signed({1'b0, desired_speed})) - ERR_W'(in_speed);
    diff = DIFF_W'(err) - DIFF_W'(previous_error);

    // Saturate the running sum symmetrically
    integ_sum = (INTEG_W+1)'(error_integral) + (INTEG_W+1)'(err);
    if (integ_sum > (INTEG_W+1)'(INTEG_MAX)) begin
      error_integral_next = INTEG_MAX;
    end else if (integ_sum < -(INTEG_W+1)'(INTEG_MAX)) begin
      error_integral_next = -INTEG_MAX;
    end else begin
      error_integral_next = integ_sum[INTEG_W-1:0];
    end

    if (in_dev < -DEV_FAR) begin
      target_raw = STEER_STEP;
    end else if (in_dev > DEV_FAR) begin
      target_raw = -STEER_STEP;
    end else if (in_dev < DEV_NEAR && in_dev > -DEV_NEAR) begin
      target_raw = front_hold;
    end else begin
      target_raw = '0;
    end

    if (wake) begin
      front_hold_next = 16'(in_fang);
      target          = 16'(in_fang);
    end else begin
      front_hold_next = target_raw;
      if (target_raw > STEER_MAX) begin
        target = STEER_MAX;
      end else if (target_raw < -STEER_MAX) begin
        target = -STEER_MAX;
      end else begin
        target = target_raw;
      end
    end

    rear_neg = -target;
    if (rear_neg > REAR_MAX) rear_neg = REAR_MAX;

    side_in = '0;
    side_in.arrived = arrived_next;
    if (arrived_next) begin
      side_in.torque = TORQUE_ONE;
      side_in.brake  = brake_level;
      side_in.front  = in_fang;
      side_in.rear   = in_rang;
    end else if (in_start) begin
      side_in.use_pid = 1'b1;
      side_in.front   = target[ANGLE_W-1:0];
      side_in.rear    = rear_neg[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_integral <= '0;
      previous_error <= '0;
      front_hold     <= '0;
      steering_awake <= 1'b0;
      angle_seen     <= 1'b0;
      arrived_latch  <= 1'b0;
    end else if (accept) begin
      if (run_pid) begin
        error_integral <= error_integral_next;
        previous_error <= err;
      end
      front_hold    <= front_hold_next;
      angle_seen    <= angle_seen_next;
      arrived_latch <= arrived_next;
      if (wake) steering_awake <= 1'b1;
    end
  end

  // Stage 1: magnitudes and signs of the three PID operands
  logic [ERR_W-1:0]   s1_mag_e;
  logic [DIFF_W-1:0]  s1_mag_d;
  logic [MAGI_W-1:0]  s1_mag_i;
  logic               s1_neg_e, s1_neg_d, s1_neg_i;
  side_t              s1_side;

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      s1_neg_e <= err < 0;
      s1_neg_d <= diff < 0;
      s1_neg_i <= error_integral_next < 0;
      s1_mag_e <= (err < 0) ? ERR_W'(-err) : ERR_W'(err);
      s1_mag_d <= (diff < 0) ? DIFF_W'(-diff) : DIFF_W'(diff);
      s1_mag_i <= (error_integral_next < 0) ? MAGI_W'(-error_integral_next)
                                            : MAGI_W'(error_integral_next);
      s1_side  <= side_in;
    end
  end

  // Stage 2: gain products, integral product split in two halves
  logic [Q_W+ERR_W-1:0]           s2_prod_p;
  logic [Q_W+DIFF_W-1:0]          s2_prod_d;
  logic [Q_W+IHALF_W-1:0]         s2_prod_ilo;
  logic [Q_W+MAGI_W-IHALF_W-1:0]  s2_prod_ihi;
  logic                           s2_neg_e, s2_neg_d, s2_neg_i;
  side_t                          s2_side;

  always_ff @(posedge clk) begin
    if (r2) begin
      s2_prod_p   <= gain_p * s1_mag_e;
      s2_prod_d   <= gain_d * s1_mag_d;
      s2_prod_ilo <= gain_i * s1_mag_i[IHALF_W-1:0];
      s2_prod_ihi <= gain_i * s1_mag_i[MAGI_W-1:IHALF_W];
      s2_neg_e    <= s1_neg_e;
      s2_neg_d    <= s1_neg_d;
      s2_neg_i    <= s1_neg_i;
      s2_side     <= s1_side;
    end
  end

  // Stage 3: saturate the integral term and apply signs
  logic [70:0]               prod_i_full;
  logic [TERM_W-1:0]         mag_i_sat;
  logic signed [TERM_W-1:0]  s3_term_p, s3_term_d, s3_term_i;
  side_t                     s3_side;

  always_comb begin
    prod_i_full = {s2_prod_ihi, {IHALF_W{1'b0}}} + 71'(s2_prod_ilo);
    mag_i_sat   = (prod_i_full > TERM_SAT) ? TERM_SAT[TERM_W-1:0]
                                           : prod_i_full[TERM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      s3_term_p <= s2_neg_e ? -TERM_W'(s2_prod_p) : TERM_W'(s2_prod_p);
      s3_term_d <= s2_neg_d ? -TERM_W'(s2_prod_d) : TERM_W'(s2_prod_d);
      s3_term_i <= s2_neg_i ? -$signed(mag_i_sat) : $signed(mag_i_sat);
      s3_side   <= s2_side;
    end
  end

  // Stage 4: sum of the three terms
  logic signed [SUM_W-1:0] s4_sum;
  side_t                   s4_side;

  always_ff @(posedge clk) begin
    if (r4) begin
      s4_sum  <= SUM_W'(s3_term_p) + SUM_W'(s3_term_i) + SUM_W'(s3_term_d);
      s4_side <= s3_side;
    end
  end

  // Stage 5: floor shift, offset, clamps, then the output register
  logic signed [SUM_W-1:0] sum_shifted;
  logic signed [63:0]      torque_full;
  logic [30:0]             torque_pos;
  logic [Q_W-1:0]          torque_lim, torque_pid;

  always_comb begin
    sum_shifted = s4_sum >>> FRACTION_BITS;
    torque_full = 64'(sum_shifted) + 64'($signed({1'b0, torque_offset}));
    if (torque_full < 0) begin
      torque_pos = '0;
    end else if (torque_full > 64'sh7FFF_FFFF) begin
      torque_pos = 31'h7FFF_FFFF;
    end else begin
      torque_pos = torque_full[30:0];
    end
    torque_lim = (torque_pos > 31'(torque_limit)) ? torque_limit : torque_pos[Q_W-1:0];
    torque_pid = (torque_lim < TORQUE_FLOOR) ? TORQUE_FLOOR : torque_lim;
  end

  logic [Q_W-1:0]            out_torque;
  logic [BRAKE_W-1:0]        out_brake;
  logic signed [ANGLE_W-1:0] out_front, out_rear;
  logic                      out_arrived;

  always_ff @(posedge clk) begin
    if (r5) begin
      out_torque  <= s4_side.use_pid ? torque_pid : s4_side.torque;
      out_brake   <= s4_side.brake;
      out_front   <= s4_side.front;
      out_rear    <= s4_side.rear;
      out_arrived <= s4_side.arrived;
    end
  end

  assign m_axis_tvalid = v5;
  assign m_axis_tdata  = {2'b00, out_rear, out_front, out_brake, out_torque};
  assign m_axis_tuser  = out_arrived;

  // The arrival latch never clears once set
  a_arrived_sticky: assert property (@(posedge clk) disable iff (rst)
    arrived_latch |=> arrived_latch)
    else $error("arrival latch cleared");

  // Steering cannot wake before an angle was seen
  a_awake_needs_angle: assert property (@(posedge clk) disable iff (rst)
    steering_awake |-> angle_seen)
    else $error("steering awake without angle");

  // Integral saturates symmetrically, the most negative code is unreachable
  a_integral_range: assert property (@(posedge clk) disable iff (rst)
    error_integral != {1'b1, {(INTEG_W-1){1'b0}}})
    else $error("integral out of range");

  // A driving torque before arrival never drops below the floor
  a_torque_floor: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] && m_axis_tdata[Q_W-1:0] != '0
      |-> m_axis_tdata[Q_W-1:0] >= TORQUE_FLOOR)
    else $error("torque below floor");

endmodule
